[rtl/core/eac_pkg.sv]
package eac_pkg;

    localparam int FRAC_BITS = 8;

    localparam int ANG_W   = 32;
    localparam int HEAD_W  = 17;
    localparam int PITCH_W = 16;
    localparam int BANK_W  = 17;

    localparam longint HALF_TURN    = longint'(180) << FRAC_BITS;
    localparam longint FULL_TURN    = longint'(360) << FRAC_BITS;
    localparam longint QUARTER_TURN = longint'(90) << FRAC_BITS;

    // full turn = 45 * 2^(FRAC_BITS+3): low bits pass, the rest is reduced mod 45
    localparam int LOW_W   = FRAC_BITS + 3;
    localparam int MOD_RES = 45;
    localparam int R45_W   = 6;
    localparam int REM_W   = R45_W + LOW_W;

    // operand of a wrap unit holds h +/- b, which needs 33 bits
    localparam int     V_W     = 34;
    localparam int     U_W     = 35;
    localparam longint SPAN    = longint'(1) << 33;
    localparam longint WRAP_K  = FULL_TURN * ((SPAN + FULL_TURN - 1) / FULL_TURN);
    localparam longint WRAP_OFS = WRAP_K + HALF_TURN;

    // 2^12 = 1 mod 45, so 12-bit chunks of the quotient add up mod 45
    localparam int Q_W    = U_W - LOW_W;
    localparam int CH_W   = 12;
    localparam int NCH    = (Q_W + CH_W - 1) / CH_W;
    localparam int QP_W   = NCH * CH_W;
    localparam int SUM_W  = 14;
    localparam int FOLD_W = 13;
    localparam int RECIP_SH = 16;
    localparam int RECIP  = (1 << RECIP_SH) / MOD_RES;
    localparam int RCP_W  = 11;
    localparam int QQ_W   = 7;

    typedef logic signed [V_W-1:0] t_wide;
    typedef logic [REM_W-1:0]      t_rem;
    typedef logic signed [REM_W:0] t_sang;

endpackage

[rtl/core/eac_if.sv]
interface eac_in_if import eac_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] heading_in;
    logic signed [ANG_W-1:0] pitch_in;
    logic signed [ANG_W-1:0] bank_in;

    modport source (output valid, output heading_in, output pitch_in, output bank_in,
                    input ready);
    modport sink   (input valid, input heading_in, input pitch_in, input bank_in,
                    output ready);
endinterface

interface eac_out_if import eac_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [HEAD_W-1:0]  heading_out;
    logic signed [PITCH_W-1:0] pitch_out;
    logic signed [BANK_W-1:0]  bank_out;
    logic                      was_canonical;

    modport source (output valid, output heading_out, output pitch_out, output bank_out,
                    output was_canonical, input ready);
    modport sink   (input valid, input heading_out, input pitch_out, input bank_out,
                    input was_canonical, output ready);
endinterface

[rtl/core/eac_wrap.sv]
module eac_wrap import eac_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_wide i_v,
    output t_rem  o_rem
);

    // stage 1: shift into positive range, offset is a multiple of a full turn plus a half
    logic [U_W-1:0] n_u;
    logic [U_W-1:0] r_u;

    assign n_u = U_W'(i_v) + U_W'(WRAP_OFS);

    // stage 2: fold the quotient bits mod 45
    logic [QP_W-1:0]  q_pad;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] r_sum;
    logic [LOW_W-1:0] r_lo2;

    assign q_pad = QP_W'(r_u[U_W-1:LOW_W]);

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NCH; k++) begin
            n_sum = n_sum + SUM_W'(q_pad[k*CH_W +: CH_W]);
        end
    end

    // stage 3: second fold, quotient estimate by reciprocal
    logic [FOLD_W-1:0]       n_s2;
    logic [FOLD_W+RCP_W-1:0] prod;
    logic [FOLD_W-1:0]       r_s2;
    logic [QQ_W-1:0]         r_qq;
    logic [LOW_W-1:0]        r_lo3;

    assign n_s2 = FOLD_W'(r_sum[CH_W-1:0]) + FOLD_W'(r_sum[SUM_W-1:CH_W]);
    assign prod = (FOLD_W+RCP_W)'(n_s2) * (FOLD_W+RCP_W)'(RECIP);

    // stage 4: remainder, estimate may be one low
    logic [FOLD_W-1:0] qm;
    logic [QQ_W-1:0]   d;
    logic [R45_W-1:0]  r45;
    t_rem              r_rem;

    assign qm  = FOLD_W'(r_qq) * FOLD_W'(MOD_RES);
    assign d   = QQ_W'(r_s2 - qm);
    assign r45 = (d >= QQ_W'(MOD_RES)) ? R45_W'(d - QQ_W'(MOD_RES)) : R45_W'(d);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u   <= n_u;
            r_sum <= n_sum;
            r_lo2 <= r_u[LOW_W-1:0];
            r_s2  <= n_s2;
            r_qq  <= prod[RECIP_SH +: QQ_W];
            r_lo3 <= r_lo2;
            r_rem <= {r45, r_lo3};
        end
    end

    assign o_rem = r_rem;

endmodule

[rtl/core/euler_angle_canonize_top.sv]
// heading / pitch / bank canonizer, signed fixed point angles in degrees
//
// input channel i_in carries one raw angle triple per beat; output channel
// o_out carries the canonical triple and a flag that is set when the input
// already met the canonical rules (heading and bank in (-180,180], pitch in
// [-90,90], bank zero at gimbal lock).
//
// the path from the accepting edge to o_out is six registers deep (one input
// register, four stages of the mod-360 wrap units, one output stage), the
// first of them loaded at the accepting edge.
// throughput is one beat per cycle while the receiver takes results; five wrap
// units (pitch, heading, bank, heading+bank, heading-bank) run side by side, so
// every candidate is ready when the pitch decides which one is taken.
//
// reset empties the pipeline; there is no other state. when the receiver
// holds off ready while o_out is valid the whole pipeline freezes and
// i_in.ready drops in the same cycle, so no beat is dropped or repeated. ready
// stays high while the output register is empty, so bubbles never block input.
module euler_angle_canonize_top import eac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eac_in_if.sink    i_in,
    eac_out_if.source o_out
);

    localparam int NSTG = 6;
    localparam int OUT  = NSTG - 1;

    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(HALF_TURN);
    localparam logic signed [ANG_W-1:0] ANG_QTR  = ANG_W'(QUARTER_TURN);

    localparam t_rem REM_HALF  = REM_W'(HALF_TURN);
    localparam t_rem REM_QTR   = REM_W'(QUARTER_TURN);
    localparam t_rem REM_3QTR  = REM_W'(HALF_TURN + QUARTER_TURN);
    localparam t_sang SA_HALF  = t_sang'(HALF_TURN);
    localparam t_sang SA_FULL  = t_sang'(FULL_TURN);

    function automatic t_rem add_half(t_rem r);
        add_half = (r >= REM_HALF) ? t_rem'(r - REM_HALF) : t_rem'(r + REM_HALF);
    endfunction

    // residue of v+180 back to an angle, -180 shows as +180
    function automatic t_sang to_angle(t_rem r);
        if (r == '0) begin
            to_angle = SA_HALF;
        end else begin
            to_angle = t_sang'({1'b0, r}) - SA_HALF;
        end
    endfunction

    logic en;
    logic [NSTG-1:0] r_vld;
    logic [OUT-1:0]  r_cn;

    assign en         = !r_vld[OUT] || o_out.ready;
    assign i_in.ready = en;

    // stage 0: input register and canonical check
    logic signed [ANG_W-1:0] r_h0;
    logic signed [ANG_W-1:0] r_p0;
    logic signed [ANG_W-1:0] r_b0;
    logic h_ok;
    logic p_ok;
    logic b_ok;
    logic lock_ok;
    logic n_cn;

    assign h_ok    = (i_in.heading_in > -ANG_HALF) && (i_in.heading_in <= ANG_HALF);
    assign p_ok    = (i_in.pitch_in >= -ANG_QTR) && (i_in.pitch_in <= ANG_QTR);
    assign b_ok    = (i_in.bank_in > -ANG_HALF) && (i_in.bank_in <= ANG_HALF);
    assign lock_ok = !((i_in.pitch_in == ANG_QTR || i_in.pitch_in == -ANG_QTR)
                       && i_in.bank_in != '0);
    assign n_cn    = h_ok && p_ok && b_ok && lock_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h0 <= i_in.heading_in;
            r_p0 <= i_in.pitch_in;
            r_b0 <= i_in.bank_in;
            r_cn <= {r_cn[OUT-2:0], n_cn};
        end
    end

    // stages 1 to 4: wrap units
    t_rem rem_p;
    t_rem rem_h;
    t_rem rem_b;
    t_rem rem_hpb;
    t_rem rem_hmb;

    eac_wrap u_wrap_p (
        .i_clk (i_clk), .i_en (en), .i_v (t_wide'(r_p0)), .o_rem (rem_p)
    );

    eac_wrap u_wrap_h (
        .i_clk (i_clk), .i_en (en), .i_v (t_wide'(r_h0)), .o_rem (rem_h)
    );

    eac_wrap u_wrap_b (
        .i_clk (i_clk), .i_en (en), .i_v (t_wide'(r_b0)), .o_rem (rem_b)
    );

    eac_wrap u_wrap_hpb (
        .i_clk (i_clk), .i_en (en), .i_v (t_wide'(r_h0) + t_wide'(r_b0)), .o_rem (rem_hpb)
    );

    eac_wrap u_wrap_hmb (
        .i_clk (i_clk), .i_en (en), .i_v (t_wide'(r_h0) - t_wide'(r_b0)), .o_rem (rem_hmb)
    );

    // stage 5: pitch decides lock, mirror or pass
    logic  lock_pos;
    logic  lock_neg;
    logic  mir_hi;
    logic  mir_lo;
    t_sang p_ang;
    t_rem  h_sel;
    t_sang h_ang;
    t_sang b_ang;

    assign lock_pos = (rem_p == REM_3QTR);
    assign lock_neg = (rem_p == REM_QTR);
    assign mir_hi   = (rem_p > REM_3QTR);
    assign mir_lo   = (rem_p < REM_QTR);

    always_comb begin
        priority if (mir_hi) begin
            p_ang = SA_FULL - t_sang'({1'b0, rem_p});
        end else if (mir_lo) begin
            p_ang = -t_sang'({1'b0, rem_p});
        end else begin
            p_ang = t_sang'({1'b0, rem_p}) - SA_HALF;
        end
    end

    always_comb begin
        priority if (lock_pos) begin
            h_sel = rem_hpb;
            b_ang = '0;
        end else if (lock_neg) begin
            h_sel = rem_hmb;
            b_ang = '0;
        end else if (mir_hi || mir_lo) begin
            h_sel = add_half(rem_h);
            b_ang = to_angle(add_half(rem_b));
        end else begin
            h_sel = rem_h;
            b_ang = to_angle(rem_b);
        end
    end

    assign h_ang = to_angle(h_sel);

    logic signed [HEAD_W-1:0]  r_head;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [BANK_W-1:0]  r_bank;
    logic                      r_was;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head  <= HEAD_W'(h_ang);
            r_pitch <= PITCH_W'(p_ang);
            r_bank  <= BANK_W'(b_ang);
            r_was   <= r_cn[OUT-1];
        end
    end

    assign o_out.valid         = r_vld[OUT];
    assign o_out.heading_out   = r_head;
    assign o_out.pitch_out     = r_pitch;
    assign o_out.bank_out      = r_bank;
    assign o_out.was_canonical = r_was;

endmodule
